// File: rtl/core/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared codes and constants of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int FRAC_BITS = 8;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_LOAD_C  = 2'd2,
		CMD_COMPUTE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TRANSPOSE_A = 3'd0,
		REG_TRANSPOSE_B = 3'd1,
		REG_ALPHA       = 3'd2,
		REG_BETA        = 3'd3,
		REG_ROWS_M      = 3'd4,
		REG_COLS_N      = 3'd5,
		REG_INNER_K     = 3'd6,
		REG_UNUSED      = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

endpackage

// File: rtl/core/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/mma_cell.sv
// ----------------------------------------------------------------------------
// mma_cell
// One cell of the reduction chain: adds the product of its own inner index
// to the partial sum handed on by its neighbor.
// ----------------------------------------------------------------------------
module mma_cell #(
	parameter int IDX    = 0,
	parameter int IW     = 3,
	parameter int ACC_W  = 35,
	parameter int PROD_W = 32
) (
	input  logic                     clk,
	input  logic                     prod_vld,
	input  logic [IW-1:0]            prod_idx,
	input  logic signed [PROD_W-1:0] prod,
	input  logic signed [ACC_W-1:0]  sum_in,
	output logic signed [ACC_W-1:0]  sum_out
);

	logic signed [ACC_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (prod_vld && prod_idx == IW'(IDX)) begin
			sum_q <= sum_in + ACC_W'(prod);
		end else begin
			sum_q <= sum_in;
		end
	end

	assign sum_out = sum_q;

endmodule

// File: rtl/core/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Computes alpha*op(A)*op(B) + beta*C in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// s_* carries commands: tuser holds cmd, tdata holds row_index, col_index and
// elem_value. A load writes one element into the A, B or C store. A compute
// command emits rows_m x cols_n results on m_* in row-major order, tlast on
// the final one, tuser holding the saturation flag. Each result takes inner_k
// store reads, one product per cycle entering the chain of accumulator
// cells, then the read latency, the alpha/beta multiply, the round and the
// saturate stages. The block accepts no command until the last result has
// been transferred. cfg_* writes a register (index as in the register list);
// the user must write only while idle, which the block does not enforce; it
// is always ready. A stalled receiver holds the result in the output register
// and the sequencer waits. Reset restores the register defaults; the stores
// are not cleared and must be loaded before they are used.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate
	import mma_pkg::*;
#(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// row_index[2:0], col_index[5:3], elem_value, zero fill
	input  logic [((6+DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_row[2:0], out_col[5:3], out_value, zero fill
	output logic [((6+DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// saturated[0]
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data
);

	localparam int DW     = DATA_WIDTH;
	localparam int TD_W   = ((6 + DW + 7) / 8) * 8;
	localparam int IW     = $clog2(MAX_DIM);
	localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
	localparam int PROD_W = 2 * DW;
	localparam int ACC_W  = 2 * DW + IW + 1;
	localparam int MA_W   = ACC_W + DW;
	localparam int TOT_W  = MA_W + 1;
	localparam logic signed [TOT_W-1:0] ROUND = TOT_W'(1) <<< (2 * FRAC_BITS - 1);
	localparam logic signed [TOT_W-1:0] MAXV  = TOT_W'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic signed [TOT_W-1:0] MINV  = -MAXV - TOT_W'(1);

	// configuration
	logic                 trans_a_q, trans_b_q;
	logic signed [DW-1:0] alpha_q, beta_q;
	logic [3:0]           rows_q, cols_q, inner_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_a_q <= 1'b0;
			trans_b_q <= 1'b0;
			alpha_q   <= DW'(256);
			beta_q    <= '0;
			rows_q    <= 4'd8;
			cols_q    <= 4'd8;
			inner_q   <= 4'd8;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRANSPOSE_A: trans_a_q <= cfg_data[0];
				REG_TRANSPOSE_B: trans_b_q <= cfg_data[0];
				REG_ALPHA:       alpha_q   <= cfg_data;
				REG_BETA:        beta_q    <= cfg_data;
				REG_ROWS_M:      rows_q    <= cfg_data[3:0];
				REG_COLS_N:      cols_q    <= cfg_data[3:0];
				REG_INNER_K:     inner_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	function automatic logic [IW-1:0] dim_last(input logic [3:0] v);
		if (v == 4'd0) begin
			return '0;
		end else if (int'(v) > MAX_DIM) begin
			return IW'(MAX_DIM - 1);
		end else begin
			return IW'(v - 4'd1);
		end
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(r) * AW'(MAX_DIM) + AW'(c);
	endfunction

	logic [IW-1:0] m_last, n_last, k_last;
	assign m_last = dim_last(rows_q);
	assign n_last = dim_last(cols_q);
	assign k_last = dim_last(inner_q);

	// sequencer
	state_t        state_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic          in_xfer, out_xfer, elem_last;
	cmd_t          cmd;
	logic [2:0]    ld_row, ld_col;
	logic          ld_ok;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = m_tvalid && m_tready;
	assign cmd       = cmd_t'(s_tuser);
	assign ld_row    = s_tdata[2:0];
	assign ld_col    = s_tdata[5:3];
	assign ld_ok     = (int'(ld_row) < MAX_DIM) && (int'(ld_col) < MAX_DIM);
	assign elem_last = (i_q == m_last) && (j_q == n_last);

	logic vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && cmd == CMD_COMPUTE) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (k_q == k_last) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_WAIT: begin
					if (vld_s5) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						k_q <= '0;
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							if (j_q == n_last) begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + IW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stores
	logic          issue, issue_last;
	logic [AW-1:0] wr_addr, a_addr, b_addr, c_addr;
	logic [DW-1:0] a_rd, b_rd, c_rd;
	logic          wr_a, wr_b, wr_c;

	assign issue      = (state_q == ST_RUN);
	assign issue_last = issue && (k_q == k_last);
	assign wr_addr    = addr_of(ld_row[IW-1:0], ld_col[IW-1:0]);
	assign wr_a       = in_xfer && ld_ok && cmd == CMD_LOAD_A;
	assign wr_b       = in_xfer && ld_ok && cmd == CMD_LOAD_B;
	assign wr_c       = in_xfer && ld_ok && cmd == CMD_LOAD_C;
	assign a_addr     = trans_a_q ? addr_of(k_q, i_q) : addr_of(i_q, k_q);
	assign b_addr     = trans_b_q ? addr_of(j_q, k_q) : addr_of(k_q, j_q);
	assign c_addr     = addr_of(i_q, j_q);

	mma_ram #(.WIDTH(DW), .DEPTH(MAX_DIM * MAX_DIM)) u_a_store (
		.clk(clk), .wr_en(wr_a), .wr_addr(wr_addr), .wr_data(s_tdata[6+DW-1:6]),
		.rd_en(issue), .rd_addr(a_addr), .rd_data(a_rd)
	);
	mma_ram #(.WIDTH(DW), .DEPTH(MAX_DIM * MAX_DIM)) u_b_store (
		.clk(clk), .wr_en(wr_b), .wr_addr(wr_addr), .wr_data(s_tdata[6+DW-1:6]),
		.rd_en(issue), .rd_addr(b_addr), .rd_data(b_rd)
	);
	mma_ram #(.WIDTH(DW), .DEPTH(MAX_DIM * MAX_DIM)) u_c_store (
		.clk(clk), .wr_en(wr_c), .wr_addr(wr_addr), .wr_data(s_tdata[6+DW-1:6]),
		.rd_en(issue_last), .rd_addr(c_addr), .rd_data(c_rd)
	);

	// product stage
	logic                     vld_s1, last_s1, vld_s2, last_s2, vld_s3, vld_s4;
	logic [IW-1:0]            idx_s1, idx_s2;
	logic signed [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			vld_s3  <= last_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= k_q;
		idx_s2  <= idx_s1;
		prod_s2 <= $signed(a_rd) * $signed(b_rd);
	end

	// reduction chain, one cell per inner index
	logic signed [ACC_W-1:0] chain [MAX_DIM+1];
	assign chain[0] = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mma_cell #(.IDX(g), .IW(IW), .ACC_W(ACC_W), .PROD_W(PROD_W)) u_cell (
			.clk(clk), .prod_vld(vld_s2), .prod_idx(idx_s2), .prod(prod_s2),
			.sum_in(chain[g]), .sum_out(chain[g+1])
		);
	end

	logic signed [ACC_W-1:0] acc;
	always_comb begin
		acc = chain[1];
		for (int c = 0; c < MAX_DIM; c++) begin
			if (k_last == IW'(c)) begin
				acc = chain[c+1];
			end
		end
	end

	// scale, round, saturate
	logic signed [MA_W-1:0]   mul_a_s4;
	logic signed [PROD_W-1:0] mul_c_s4;
	logic signed [TOT_W-1:0]  tot_s5, tot_sum;

	assign tot_sum = TOT_W'(mul_a_s4) + (TOT_W'(mul_c_s4) <<< FRAC_BITS) + ROUND;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			mul_a_s4 <= MA_W'(acc) * MA_W'(alpha_q);
			mul_c_s4 <= $signed(beta_q) * $signed(c_rd);
		end
		if (vld_s4) begin
			tot_s5 <= tot_sum >>> (2 * FRAC_BITS);
		end
	end

	logic [DW-1:0] val_q;
	logic          sat_q, last_q, tvalid_q;
	logic [IW-1:0] row_q, col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (vld_s5) begin
			tvalid_q <= 1'b1;
		end else if (out_xfer) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s5) begin
			row_q  <= i_q;
			col_q  <= j_q;
			last_q <= elem_last;
			priority if (tot_s5 > MAXV) begin
				val_q <= MAXV[DW-1:0];
				sat_q <= 1'b1;
			end else if (tot_s5 < MINV) begin
				val_q <= MINV[DW-1:0];
				sat_q <= 1'b1;
			end else begin
				val_q <= tot_s5[DW-1:0];
				sat_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = TD_W'({val_q, 3'(col_q), 3'(row_q)});
	assign m_tuser  = sat_q;
	assign m_tlast  = last_q;

endmodule

// File: verif/matrix_multiply_accumulate_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// Self-checking bench for the fixed-point multiply-accumulate block. Loads
// and compute commands go in on the slave stream. Every result that comes
// out is compared with a local Q7.8 calculation of alpha*op(A)*op(B)+beta*C.
// Both stream sides stall at random, and the register settings change
// between phases.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;
	import mma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM        = 8;
	localparam int DW         = 16;
	localparam int TDW        = ((6 + DW + 7) / 8) * 8;
	localparam int CYCLE_CAP  = 600000;
	localparam int DRAIN_WAIT = 30;

	typedef struct {
		logic [2:0]    row;
		logic [2:0]    col;
		logic [DW-1:0] value;
		logic          sat;
		logic          last;
	} mac_result_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [TDW-1:0] s_tdata = '0;
	logic [1:0]     s_tuser = CMD_LOAD_A;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [TDW-1:0] m_tdata;
	logic           m_tuser;
	logic           m_tlast;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = REG_TRANSPOSE_A;
	logic [DW-1:0]  cfg_data = '0;

	// shadow of the stores and registers
	logic signed [DW-1:0] a_mem [DIM][DIM];
	logic signed [DW-1:0] b_mem [DIM][DIM];
	logic signed [DW-1:0] c_mem [DIM][DIM];
	bit                   a_set [DIM][DIM];
	bit                   b_set [DIM][DIM];
	bit                   c_set [DIM][DIM];
	bit                   trans_a, trans_b;
	logic signed [DW-1:0] alpha_q, beta_q;
	logic [3:0]           rows_q, cols_q, inner_q;

	mac_result_t pending_results[$];

	int  errors = 0;
	int  items_sent = 0;
	int  computes = 0;
	int  results_seen = 0;
	int  sat_seen = 0;
	int  cycles = 0;
	bit  tx_jitter = 1'b1;
	bit  rx_jitter = 1'b1;
	int  rx_hold = 0;

	matrix_multiply_accumulate #(.MAX_DIM(DIM), .DATA_WIDTH(DW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int eff_dim(logic [3:0] v);
		if (v == 0)
			return 1;
		return (v > DIM) ? DIM : int'(v);
	endfunction

	// works out every element of one compute run, row-major
	function automatic void predict_product();
		int          m, n, kk;
		longint      acc, tot;
		mac_result_t r;
		m = eff_dim(rows_q);
		n = eff_dim(cols_q);
		kk = eff_dim(inner_q);
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int k = 0; k < kk; k++) begin
					acc += longint'(trans_a ? a_mem[k][i] : a_mem[i][k]) *
						longint'(trans_b ? b_mem[j][k] : b_mem[k][j]);
				end
				tot = acc * longint'(alpha_q) +
					((longint'(beta_q) * longint'(c_mem[i][j])) <<< 8) + 64'sd32768;
				tot = tot >>> 16;
				r.row = i[2:0];
				r.col = j[2:0];
				r.sat = 1'b1;
				if (tot > 32767)
					r.value = 16'h7fff;
				else if (tot < -32768)
					r.value = 16'h8000;
				else begin
					r.value = tot[DW-1:0];
					r.sat = 1'b0;
				end
				r.last = (i == m - 1) && (j == n - 1);
				pending_results.push_back(r);
			end
		end
	endfunction

	task automatic send_item(cmd_t cmd, logic [2:0] row, logic [2:0] col, logic [DW-1:0] v);
		int gap;
		gap = tx_jitter ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, v, col, row};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		case (cmd)
			CMD_LOAD_A: begin a_mem[row][col] = v; a_set[row][col] = 1'b1; end
			CMD_LOAD_B: begin b_mem[row][col] = v; b_set[row][col] = 1'b1; end
			CMD_LOAD_C: begin c_mem[row][col] = v; c_set[row][col] = 1'b1; end
			default: begin
				computes++;
				predict_product();
			end
		endcase
	endtask

	// let everything drain; loads have no result, so keep waiting after the last expected result
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() > 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TRANSPOSE_A: trans_a = data[0];
			REG_TRANSPOSE_B: trans_b = data[0];
			REG_ALPHA:       alpha_q = data;
			REG_BETA:        beta_q = data;
			REG_ROWS_M:      rows_q = data[3:0];
			REG_COLS_N:      cols_q = data[3:0];
			REG_INNER_K:     inner_q = data[3:0];
			default: ;
		endcase
		// cfg_valid drops between writes
		@(posedge clk);
	endtask

	task automatic set_shape(bit ta, bit tb, logic [DW-1:0] alpha, logic [DW-1:0] beta,
			logic [3:0] m, logic [3:0] n, logic [3:0] k);
		write_reg(REG_TRANSPOSE_A, {15'($urandom_range(0, 32767)), ta});
		write_reg(REG_TRANSPOSE_B, {15'($urandom_range(0, 32767)), tb});
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		write_reg(REG_ROWS_M, {12'h000, m});
		write_reg(REG_COLS_N, {12'h000, n});
		write_reg(REG_INNER_K, {12'h000, k});
	endtask

	// loads any entry the next compute reads that was never written
	task automatic load_missing();
		int m, n, kk;
		m = eff_dim(rows_q);
		n = eff_dim(cols_q);
		kk = eff_dim(inner_q);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < kk; k++) begin
				if (trans_a ? !a_set[k][i] : !a_set[i][k])
					send_item(CMD_LOAD_A, 3'(trans_a ? k : i), 3'(trans_a ? i : k),
						16'($urandom));
			end
		for (int k = 0; k < kk; k++)
			for (int j = 0; j < n; j++) begin
				if (trans_b ? !b_set[j][k] : !b_set[k][j])
					send_item(CMD_LOAD_B, 3'(trans_b ? j : k), 3'(trans_b ? k : j),
						16'($urandom));
			end
		for (int i = 0; i < m; i++)
			for (int j = 0; j < n; j++)
				if (!c_set[i][j])
					send_item(CMD_LOAD_C, 3'(i), 3'(j), 16'($urandom));
	endtask

	task automatic compute_now();
		load_missing();
		send_item(CMD_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	// receiver: per-result stall, or one long hold when requested
	initial begin
		int gap;
		forever begin
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end else
				gap = rx_jitter ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		mac_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser)
				sat_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result transfer: row %0d col %0d value %h",
					$time, m_tdata[2:0], m_tdata[5:3], m_tdata[21:6]);
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[2:0] !== e.row || m_tdata[5:3] !== e.col ||
						m_tdata[21:6] !== e.value || m_tuser !== e.sat || m_tlast !== e.last) begin
					errors++;
					$display("%0t mismatch: expected row %0d col %0d value %h sat %b last %b",
						$time, e.row, e.col, e.value, e.sat, e.last);
					$display("%0t           actual   row %0d col %0d value %h sat %b last %b",
						$time, m_tdata[2:0], m_tdata[5:3], m_tdata[21:6], m_tuser, m_tlast);
				end
			end
		end
	end

	task automatic test_saturation_and_extremes();
		set_shape(1'b0, 1'b0, 16'sd32767, 16'sd32767, 4'd0, 4'd1, 4'd1);
		send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff);
		send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h7fff);
		send_item(CMD_LOAD_C, 3'd0, 3'd0, 16'h7fff);
		compute_now();
		wait_idle();
		write_reg(REG_ALPHA, 16'h8000);
		compute_now();
		send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
		send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
		compute_now();
		wait_idle();
		write_reg(REG_ALPHA, 16'h0000);
		write_reg(REG_BETA, 16'h8000);
		send_item(CMD_LOAD_C, 3'd0, 3'd0, 16'h8000);
		compute_now();
		// half-lsb tie rounds up
		send_item(CMD_LOAD_C, 3'd0, 3'd0, 16'h0001);
		wait_idle();
		write_reg(REG_BETA, 16'h0080);
		compute_now();
		send_item(CMD_LOAD_A, 3'd7, 3'd7, 16'h7fff);
		send_item(CMD_LOAD_B, 3'd7, 3'd7, 16'h8000);
		send_item(CMD_LOAD_C, 3'd7, 3'd7, 16'hffff);
		wait_idle();
	endtask

	task automatic test_shapes_and_transposes();
		// out-of-range sizes clamp; index seven must be ignored
		set_shape(1'b1, 1'b1, 16'h0100, 16'h0100, 4'd15, 4'd8, 4'd0);
		write_reg(REG_UNUSED, 16'($urandom));
		compute_now();
		wait_idle();
		set_shape(1'b0, 1'b0, 16'h0100, 16'hff00, 4'd1, 4'd1, 4'd8);
		compute_now();
		wait_idle();
		set_shape(1'b1, 1'b0, 16'h0080, 16'h0000, 4'd8, 4'd8, 4'd1);
		compute_now();
		wait_idle();
	endtask

	task automatic test_random_runs(int item_goal);
		int       n_loads;
		logic [3:0] m, n, k;
		while (items_sent < item_goal) begin
			tx_jitter = ($urandom_range(0, 3) != 0);
			rx_jitter = ($urandom_range(0, 3) != 0);
			m = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
			n = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
			k = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
			set_shape(1'($urandom), 1'($urandom),
				16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 512)),
				16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 512) - 256),
				m, n, k);
			n_loads = $urandom_range(0, 10);
			repeat (n_loads)
				send_item(cmd_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom),
					16'($urandom));
			compute_now();
			if ($urandom_range(0, 2) == 0)
				compute_now();
			wait_idle();
		end
	endtask

	task automatic test_output_backpressure();
		set_shape(1'b0, 1'b1, 16'($urandom), 16'($urandom), 4'd4, 4'd4, 4'd3);
		load_missing();
		tx_jitter = 1'b0;
		rx_hold = 400;
		compute_now();
		send_item(CMD_LOAD_C, 3'd1, 3'd1, 16'($urandom));
		compute_now();
		tx_jitter = 1'b1;
		wait_idle();
	endtask

	initial begin
		trans_a = 1'b0;
		trans_b = 1'b0;
		alpha_q = 16'sd256;
		beta_q = 16'sd0;
		rows_q = 4'd8;
		cols_q = 4'd8;
		inner_q = 4'd8;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_saturation_and_extremes();
		test_shapes_and_transposes();
		test_output_backpressure();
		test_random_runs(230);
		wait_idle();
		$display("covered %0d commands, %0d compute runs, %0d results (%0d clipped)",
			items_sent, computes, results_seen, sat_seen);
		$display("sizes 1 to 8 with clamping, both transposes, scale extremes, stalls");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
